FILE: rtl/core/skfu_pkg.sv
// Package for the session key frame unpacker: phase and result-entry types,
// status and kind codes, and fixed frame constants. No dependencies.
`timescale 1ns / 1ps

package skfu_pkg;

    // Frame layout constants.
    localparam logic [7:0] BLOCK_TYPE    = 8'd2;
    localparam logic [5:0] KEY_LEN_RESET = 6'd16;
    localparam logic [5:0] KEY_COUNT_MAX = 6'd63;
    localparam logic [5:0] MAX_KEY_BYTES = 6'd32;

    // Result kind codes.
    localparam logic KIND_KEY    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_LEN_ERR  = 2'd2;
    localparam logic [1:0] ST_SUM_ERR  = 2'd3;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_PAD  = 2'd1,
        PH_ALGO = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    // Work handed from the front to the back for one accepted byte:
    // an optional released key byte and an optional closing status.
    typedef struct packed {
        logic       has_key;
        logic [7:0] key_byte;
        logic [5:0] key_idx;
        logic [7:0] algo;
        logic       has_st;
        logic [1:0] status;
        logic [5:0] st_idx;
    } t_entry;

endpackage

FILE: rtl/core/skfu_front.sv
// Front part of the session key frame unpacker: frame parser, key sum and
// length register. Produces at most one t_entry per accepted byte. Uses skfu_pkg.
`timescale 1ns / 1ps

module skfu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [5:0]      i_cfg_wdata,
    input  logic            i_accept,
    input  logic [7:0]      i_frame_byte,
    input  logic            i_last_byte,
    output logic            o_push,
    output skfu_pkg::t_entry o_entry
);
    import skfu_pkg::*;

    logic [5:0]  r_expected_key_len;
    t_phase      r_phase, n_phase;
    logic        r_bad_type, n_bad_type;
    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [1:0]  r_held_count, n_held_count;
    logic [15:0] r_key_sum, n_key_sum;
    logic [5:0]  r_key_count, n_key_count;
    logic [7:0]  r_algo, n_algo;
    logic        r_key_over, n_key_over;
    logic        key_out;
    logic [1:0]  status;

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        if (!r_bad_type) begin
            unique case (r_phase)
                PH_TYPE: n_phase = PH_PAD;
                PH_PAD:  if (i_frame_byte == 8'd0) n_phase = PH_ALGO;
                PH_ALGO: n_phase = PH_BODY;
                PH_BODY: n_phase = PH_BODY;
                default: n_phase = PH_TYPE;
            endcase
        end
    end

    // Datapath for the byte at the input.
    always_comb begin
        n_bad_type   = r_bad_type;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_held_count = r_held_count;
        n_key_sum    = r_key_sum;
        n_key_count  = r_key_count;
        n_algo       = r_algo;
        n_key_over   = r_key_over;
        key_out      = 1'b0;
        if (!r_bad_type) begin
            unique case (r_phase)
                PH_TYPE: begin
                    if (i_frame_byte != BLOCK_TYPE) n_bad_type = 1'b1;
                end
                PH_ALGO: begin
                    n_algo = i_frame_byte;
                end
                PH_BODY: begin
                    if (r_held_count == 2'd2) begin
                        // The oldest held byte is now known to be a key byte.
                        key_out   = 1'b1;
                        n_key_sum = r_key_sum + {8'd0, r_held0};
                        if (r_key_count == KEY_COUNT_MAX) begin
                            n_key_over = 1'b1;
                        end else begin
                            n_key_count = r_key_count + 6'd1;
                        end
                        n_held0 = r_held1;
                        n_held1 = i_frame_byte;
                    end else begin
                        if (r_held_count[0]) begin
                            n_held1 = i_frame_byte;
                        end else begin
                            n_held0 = i_frame_byte;
                        end
                        n_held_count = r_held_count + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Closing status, taken on the state that includes the final byte.
    always_comb begin
        if (n_bad_type) begin
            status = ST_BAD_TYPE;
        end else if (n_phase != PH_BODY || n_held_count != 2'd2 || n_key_over ||
                     n_key_count != r_expected_key_len ||
                     n_key_count > MAX_KEY_BYTES) begin
            status = ST_LEN_ERR;
        end else if ({n_held0, n_held1} != n_key_sum) begin
            status = ST_SUM_ERR;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_entry.has_key  = key_out;
        o_entry.key_byte = r_held0;
        o_entry.key_idx  = r_key_count;
        o_entry.algo     = n_algo;
        o_entry.has_st   = i_last_byte;
        o_entry.status   = status;
        o_entry.st_idx   = n_key_count;
        o_push           = i_accept && (key_out || i_last_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_key_len <= KEY_LEN_RESET;
        end else if (i_cfg_we) begin
            r_expected_key_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase      <= PH_TYPE;
            r_bad_type   <= 1'b0;
            r_held0      <= 8'd0;
            r_held1      <= 8'd0;
            r_held_count <= 2'd0;
            r_key_sum    <= 16'd0;
            r_key_count  <= 6'd0;
            r_algo       <= 8'd0;
            r_key_over   <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bad_type   <= n_bad_type;
            r_held0      <= n_held0;
            r_held1      <= n_held1;
            r_held_count <= n_held_count;
            r_key_sum    <= n_key_sum;
            r_key_count  <= n_key_count;
            r_algo       <= n_algo;
            r_key_over   <= n_key_over;
        end
    end

endmodule

FILE: rtl/core/skfu_queue.sv
// Four-entry queue of t_entry words between the front and the back parts.
// Uses skfu_pkg.
`timescale 1ns / 1ps

module skfu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  skfu_pkg::t_entry i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output skfu_pkg::t_entry o_data
);
    import skfu_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [PW:0]     r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/skfu_back.sv
// Back part of the session key frame unpacker: takes entries from the queue
// and hands out their key and status beats in order. Uses skfu_pkg.
`timescale 1ns / 1ps

module skfu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  skfu_pkg::t_entry i_q_data,
    output logic             o_q_pop,
    input  logic             pop,
    output logic             empty,
    output logic             o_kind,
    output logic [7:0]       o_key_byte,
    output logic [5:0]       o_key_index,
    output logic [7:0]       o_algo_id,
    output logic [1:0]       o_status,
    output logic             o_end_of_frame
);
    import skfu_pkg::*;

    t_entry r_entry;
    logic   r_key_pend, r_st_pend;
    logic   take, load_ok;

    assign empty   = !(r_key_pend || r_st_pend);
    assign take    = pop && !empty;
    // The held entry is used up once nothing stays pending after this beat.
    assign load_ok = empty || (take && !(r_key_pend && r_st_pend));
    assign o_q_pop = load_ok && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_entry <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pend <= 1'b0;
            r_st_pend  <= 1'b0;
        end else if (load_ok) begin
            r_key_pend <= i_q_valid && i_q_data.has_key;
            r_st_pend  <= i_q_valid && i_q_data.has_st;
        end else if (take) begin
            r_key_pend <= 1'b0;
        end
    end

    always_comb begin
        o_kind         = r_key_pend ? KIND_KEY : KIND_STATUS;
        o_key_byte     = r_key_pend ? r_entry.key_byte : 8'd0;
        o_key_index    = r_key_pend ? r_entry.key_idx : r_entry.st_idx;
        o_algo_id      = r_entry.algo;
        o_status       = r_key_pend ? ST_OK : r_entry.status;
        o_end_of_frame = !r_key_pend;
    end

endmodule

FILE: rtl/core/session_key_frame_unpacker_top.sv
// Top level of the session key frame unpacker: front parser, entry queue and
// result back end. Depends on skfu_pkg, skfu_front, skfu_queue, skfu_back.
`timescale 1ns / 1ps

// The unpacker takes one byte of a decrypted type-2 frame (leading zero
// already removed) per beat on the push/full side and can accept a new byte
// in every clock cycle while the queue is not full. The front part parses
// the block type, padding, algorithm byte and key bytes as each byte is
// accepted and writes at most one entry per byte into a four-entry queue;
// the back part reads the queue and hands out results on the empty/pop side
// one beat per cycle. A key byte is released by the byte that proves it is
// not part of the trailing checksum, and the final byte of a frame yields a
// status beat (0 ok, 1 bad block type, 2 key length mismatch or truncated
// frame, 3 checksum error). A byte that releases a key byte and also ends
// the frame produces two beats, so the result side is the limit: the
// sustained rate is one byte per cycle as long as the consumer pops every
// cycle, and the queue absorbs the extra status beat at each frame end. The
// queue writes the entry at the edge that accepts a byte, and the back part
// then loads it from the queue into its held entry register, which drives
// the result ports. The expected key length register (reset 16) is written
// through i_cfg_we/i_cfg_wdata and should only change between frames while
// no results are outstanding.
module session_key_frame_unpacker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_frame_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_kind,
    output logic [7:0] o_key_byte,
    output logic [5:0] o_key_index,
    output logic [7:0] o_algo_id,
    output logic [1:0] o_status,
    output logic       o_end_of_frame
);
    import skfu_pkg::*;

    logic   accept;
    logic   q_push, q_pop, q_full, q_valid;
    t_entry f_entry, q_entry;

    // A byte is taken whenever the queue has room for what it may produce.
    assign full   = q_full;
    assign accept = push && !q_full;

    skfu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .o_push       (q_push),
        .o_entry      (f_entry)
    );

    skfu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    skfu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_entry),
        .o_q_pop        (q_pop),
        .pop            (pop),
        .empty          (empty),
        .o_kind         (o_kind),
        .o_key_byte     (o_key_byte),
        .o_key_index    (o_key_index),
        .o_algo_id      (o_algo_id),
        .o_status       (o_status),
        .o_end_of_frame (o_end_of_frame)
    );

`ifndef SYNTHESIS
    // The front never writes an entry that carries no beat.
    a_no_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (f_entry.has_key || f_entry.has_st))
        else $error("front pushed an entry without a beat");

    // The queue cannot report full and empty at once.
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && !q_valid))
        else $error("queue reports full and empty together");

    // A status closing the frame right after a key byte counts that byte.
    a_status_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && f_entry.has_key && f_entry.has_st && !f_entry.status[0] &&
         f_entry.key_idx != KEY_COUNT_MAX) |-> (f_entry.st_idx == f_entry.key_idx + 6'd1))
        else $error("status key count does not follow the last key index");

    // Nothing is handed to the back part from an empty queue.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end read an empty queue");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for session_key_frame_unpacker_top: random and directed frames,
// checked beat by beat against an in-bench frame parser. Depends on skfu_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;

    import skfu_pkg::*;

    // Results pass through the four-entry queue and the held entry of the back part
    // before they appear, and the drain wait gives the block time to settle.
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned RUN_LIMIT    = 100000;
    localparam int unsigned GAP_PERCENT  = 19;
    localparam int unsigned MAX_REPORTS  = 50;

    // One byte beat on the input side.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_beat_t;

    // One result beat as it should appear on the output side.
    typedef struct packed {
        logic       kind;
        logic [7:0] key_byte;
        logic [5:0] key_index;
        logic [7:0] algo_id;
        logic [1:0] status;
        logic       end_of_frame;
    } key_result_t;

    // Every input of the block has a known value from time zero.
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [5:0] i_cfg_wdata  = 6'd0;
    logic       push         = 1'b0;
    logic [7:0] i_frame_byte = 8'd0;
    logic       i_last_byte  = 1'b0;
    logic       pop          = 1'b0;

    logic       full;
    logic       empty;
    logic       o_kind;
    logic [7:0] o_key_byte;
    logic [5:0] o_key_index;
    logic [7:0] o_algo_id;
    logic [1:0] o_status;
    logic       o_end_of_frame;

    session_key_frame_unpacker_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_frame_byte   (i_frame_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_key_byte     (o_key_byte),
        .o_key_index    (o_key_index),
        .o_algo_id      (o_algo_id),
        .o_status       (o_status),
        .o_end_of_frame (o_end_of_frame)
    );

    // Bytes waiting to be offered, and result beats the parser says must come out.
    frame_beat_t frame_bytes_q[$];
    key_result_t unpacked_q[$];

    // Parser copy of the block state and its one register.
    logic [5:0] cfg_key_len = KEY_LEN_RESET;
    t_phase     frame_phase = PH_TYPE;
    logic       bad_type    = 1'b0;
    logic [7:0] held [2]    = '{8'd0, 8'd0};
    logic [1:0] held_count  = 2'd0;
    logic [15:0] key_sum    = 16'd0;
    logic [5:0] key_count   = 6'd0;
    logic [7:0] algo_byte   = 8'd0;
    logic       key_over    = 1'b0;

    // When set, neither side inserts gaps: this gives one long stretch at full rate.
    bit          steady = 1'b0;
    int unsigned mismatches = 0;
    int unsigned bytes_queued = 0;
    int unsigned frames_queued = 0;
    int unsigned beats_checked = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Frame parser. It consumes one accepted byte and appends the result beats that
    // the byte releases: possibly a key byte that can no longer be part of the
    // trailing checksum, and on the last byte the status beat that closes the frame.
    task automatic unpack_byte(input logic [7:0] b, input logic last);
        key_result_t r;
        logic [1:0]  st;
        if (!bad_type) begin
            case (frame_phase)
                PH_TYPE: begin
                    // Any first byte other than the block type poisons the frame.
                    if (b != BLOCK_TYPE) bad_type = 1'b1;
                    frame_phase = PH_PAD;
                end
                PH_PAD: begin
                    if (b == 8'd0) frame_phase = PH_ALGO;
                end
                PH_ALGO: begin
                    algo_byte   = b;
                    frame_phase = PH_BODY;
                end
                default: begin
                    // Two bytes are always held back as a possible checksum; a third
                    // byte pushes the oldest one out as a key byte.
                    if (held_count >= 2'd2) begin
                        r = '{KIND_KEY, held[0], key_count, algo_byte, ST_OK, 1'b0};
                        unpacked_q.push_back(r);
                        key_sum = key_sum + 16'(held[0]);
                        if (key_count >= KEY_COUNT_MAX) key_over = 1'b1;
                        else key_count = key_count + 6'd1;
                        held[0] = held[1];
                        held[1] = b;
                    end else begin
                        held[held_count[0]] = b;
                        held_count = held_count + 2'd1;
                    end
                end
            endcase
        end
        if (last) begin
            // Block type first, then length (truncation counts as a length error),
            // then the checksum.
            if (bad_type) st = ST_BAD_TYPE;
            else if (frame_phase != PH_BODY || held_count < 2'd2 || key_over ||
                     key_count != cfg_key_len || key_count > MAX_KEY_BYTES)
                st = ST_LEN_ERR;
            else if ({held[0], held[1]} != key_sum) st = ST_SUM_ERR;
            else st = ST_OK;
            r = '{KIND_STATUS, 8'd0, key_count, algo_byte, st, 1'b1};
            unpacked_q.push_back(r);
            frame_phase = PH_TYPE;
            bad_type    = 1'b0;
            held[0]     = 8'd0;
            held[1]     = 8'd0;
            held_count  = 2'd0;
            key_sum     = 16'd0;
            key_count   = 6'd0;
            algo_byte   = 8'd0;
            key_over    = 1'b0;
        end
    endtask

    // Driver. It offers the oldest waiting byte and holds it while the block is
    // full. The parser runs on the byte at the edge where it is taken, so its
    // view of the frame always matches what the block has seen.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                unpack_byte(i_frame_byte, i_last_byte);
                void'(frame_bytes_q.pop_front());
            end
            if (push && full) begin
                // Stalled: keep the same beat on the port.
            end else if (frame_bytes_q.size() != 0 &&
                         (steady || $urandom_range(99) >= GAP_PERCENT)) begin
                push         <= 1'b1;
                i_frame_byte <= frame_bytes_q[0].value;
                i_last_byte  <= frame_bytes_q[0].last;
            end else begin
                push <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
        end
    endtask

    // Monitor. Every beat taken from the result side is compared with the
    // oldest outstanding prediction, field by field.
    always @(posedge i_clk) begin : result_monitor
        key_result_t want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (unpacked_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result beat, expected none, actual kind %0d status %0d",
                                 $time, o_kind, o_status);
                end else begin
                    want = unpacked_q.pop_front();
                    beats_checked++;
                    if (want.kind == KIND_STATUS) status_seen[want.status]++;
                    check_field("kind", 8'(want.kind), 8'(o_kind));
                    check_field("key_byte", want.key_byte, o_key_byte);
                    check_field("key_index", 8'(want.key_index), 8'(o_key_index));
                    check_field("algo_id", want.algo_id, o_algo_id);
                    check_field("status", 8'(want.status), 8'(o_status));
                    check_field("end_of_frame", 8'(want.end_of_frame), 8'(o_end_of_frame));
                end
            end
            pop <= steady || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    task automatic queue_byte(input logic [7:0] value, input logic last);
        frame_bytes_q.push_back('{value, last});
        bytes_queued++;
        if (last) frames_queued++;
    endtask

    // Well-formed frame: block type, nonzero padding, zero, algorithm, key bytes
    // and their big-endian sum, which is corrupted when good_sum is clear.
    task automatic queue_session_frame(input int unsigned key_len, input bit good_sum);
        logic [15:0] sum;
        logic [7:0]  kb;
        int unsigned pad_len;
        sum = 16'd0;
        queue_byte(BLOCK_TYPE, 1'b0);
        pad_len = $urandom_range(3);
        repeat (pad_len) queue_byte(8'($urandom_range(255, 1)), 1'b0);
        queue_byte(8'd0, 1'b0);
        queue_byte(8'($urandom_range(255)), 1'b0);
        repeat (key_len) begin
            kb  = 8'($urandom_range(255));
            sum = sum + 16'(kb);
            queue_byte(kb, 1'b0);
        end
        if (!good_sum) sum = sum ^ 16'($urandom_range(65535, 1));
        queue_byte(sum[15:8], 1'b0);
        queue_byte(sum[7:0], 1'b1);
    endtask

    // Short frame of arbitrary bytes, led by the block type when keep_type is set;
    // such frames mostly end up truncated somewhere in the padding or the body.
    task automatic queue_broken_frame(input bit keep_type);
        int unsigned len;
        len = $urandom_range(8, 1);
        for (int unsigned i = 0; i < len; i++) begin
            if (i == 0 && keep_type) queue_byte(BLOCK_TYPE, len == 1);
            else queue_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Waits until every byte has been taken and every predicted beat has come
    // out, then lets the block settle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (frame_bytes_q.size() != 0 || push || unpacked_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The key length register may only change between frames with nothing
    // outstanding, so every write waits for the block to go quiet.
    task automatic set_key_len(input logic [5:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        cfg_key_len = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [5:0] key_len, input int unsigned budget,
                                    input bit no_gaps);
        int unsigned start;
        int unsigned sel;
        int unsigned n;
        set_key_len(key_len);
        steady = no_gaps;
        start  = bytes_queued;
        while (bytes_queued - start < budget) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                // Mostly the configured length, sometimes one off, sometimes any
                // short length, and rarely a key long enough to saturate the count.
                sel = $urandom_range(99);
                if (sel < 55) n = cfg_key_len;
                else if (sel < 70)
                    n = (cfg_key_len == 0 || $urandom_range(1)) ? cfg_key_len + 1
                                                                 : cfg_key_len - 1;
                else if (sel < 96) n = $urandom_range(40);
                else n = $urandom_range(70, 60);
                queue_session_frame(n, $urandom_range(99) < 80);
            end else if (sel < 85) begin
                queue_broken_frame(1'b1);
            end else begin
                queue_broken_frame(1'b0);
            end
        end
    endtask

    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames with a one-byte key.
        set_key_len(6'd1);
        // Good frame built from extreme values: padding, algorithm and key all 0xff.
        queue_byte(BLOCK_TYPE, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // Bad block type in a one-byte frame, and with a later byte that is ignored.
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(BLOCK_TYPE, 1'b1);
        // Frames cut short in the padding, at the algorithm byte and in the body.
        queue_byte(BLOCK_TYPE, 1'b0);
        queue_byte(8'h05, 1'b1);
        queue_byte(BLOCK_TYPE, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h07, 1'b1);
        queue_byte(BLOCK_TYPE, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h33, 1'b1);
        // Right length, wrong checksum.
        queue_byte(BLOCK_TYPE, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h02, 1'b1);

        // Random phases across key length settings, the extremes among them;
        // the 32-byte phase runs with no gaps on either side.
        run_random_phase(KEY_LEN_RESET, 185, 1'b0);
        run_random_phase(MAX_KEY_BYTES, 185, 1'b1);
        run_random_phase(6'd1, 185, 1'b0);
        run_random_phase(6'd0, 185, 1'b0);
        run_random_phase(KEY_COUNT_MAX, 185, 1'b0);
        run_random_phase(6'($urandom_range(32, 1)), 185, 1'b0);
        run_random_phase(6'($urandom_range(63)), 185, 1'b0);

        steady = 1'b0;
        wait_idle();
        if (unpacked_q.size() != 0) begin
            mismatches += unpacked_q.size();
            $display("%0t: %0d expected result beats never arrived", $time, unpacked_q.size());
        end

        $display("Sent %0d bytes in %0d frames over eight key length phases; checked %0d beats.",
                 bytes_queued, frames_queued, beats_checked);
        $display("Status beats: %0d ok, %0d bad type, %0d length, %0d checksum.",
                 status_seen[ST_OK], status_seen[ST_BAD_TYPE], status_seen[ST_LEN_ERR],
                 status_seen[ST_SUM_ERR]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/skfu_pkg.sv
rtl/core/skfu_front.sv
rtl/core/skfu_queue.sv
rtl/core/skfu_back.sv
rtl/core/session_key_frame_unpacker_top.sv
tb/sv/testbench.sv
